// File: hw/rtl/rxs_pkg.sv
// Shared types and constants for the record exchange sort block.
// Depends on nothing; rxs_xchg, record_exchange_sort and rxs_checker import it.
package rxs_pkg;

    localparam int SCORE_W         = 9;
    localparam int TAG_W           = 8;
    localparam int REC_W           = SCORE_W + TAG_W;
    localparam int TDATA_W         = ((REC_W + 7) / 8) * 8;
    localparam int MAX_RECORDS_DEF = 16;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [SCORE_W-1:0] key;
    } rec_t;

    // Commands from the sequencer to the compare-exchange unit.
    typedef struct packed {
        logic load;
        logic step;
    } xchg_ctrl_t;

endpackage

// File: hw/rtl/rxs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module rxs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/rxs_xchg.sv
// Compare-exchange unit: holds the record of the current outer position and
// compares it with each record read from the store. Depends on rxs_pkg.
module rxs_xchg (
    input  logic                aclk,
    input  rxs_pkg::xchg_ctrl_t ctrl,
    input  rxs_pkg::rec_t       rd_rec,
    output rxs_pkg::rec_t       held,
    output logic                swap
);
    import rxs_pkg::*;

    rec_t held_reg;
    rec_t held_next;

    // A strict compare, so equal keys are never exchanged.
    assign swap = held_reg.key > rd_rec.key;

    always_comb begin
        held_next = held_reg;
        if (ctrl.load || (ctrl.step && swap)) begin
            held_next = rd_rec;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg <= held_next;
    end

    assign held = held_reg;

endmodule

// File: hw/rtl/record_exchange_sort.sv
// Loading accepts a record on every valid beat, with s_tready high throughout.
// After the last record the sort takes each outer position but the final one in turn:
// it reads that record, loads it into the shared unit, does one compare-exchange per
// cycle with each later record and writes the held record back to the outer position.
// Emitting reads the RAM once per record and holds each result while m_tready is low.
// aresetn is synchronous and active low; it clears the sequencer, the record
// count and the output valid, while the record store is left as it is.
module record_exchange_sort #(
    parameter int MAX_RECORDS = rxs_pkg::MAX_RECORDS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [rxs_pkg::TDATA_W-1:0] s_tdata,   // score [8:0], tag [16:9]
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rxs_pkg::TDATA_W-1:0] m_tdata,   // sorted_score [8:0], sorted_tag [16:9]
    output logic                        m_tlast
);
    import rxs_pkg::*;

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);

    localparam logic [2:0] ST_LOAD      = 3'd0;
    localparam logic [2:0] ST_RD_OUTER  = 3'd1;
    localparam logic [2:0] ST_GET_OUTER = 3'd2;
    localparam logic [2:0] ST_INNER     = 3'd3;
    localparam logic [2:0] ST_PUT_OUTER = 3'd4;
    localparam logic [2:0] ST_EMIT_RD   = 3'd5;
    localparam logic [2:0] ST_EMIT_LD   = 3'd6;
    localparam logic [2:0] ST_EMIT_OUT  = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] outer_reg, outer_next;
    logic [CW-1:0] inner_reg, inner_next;
    logic [CW-1:0] emit_reg, emit_next;
    logic          m_valid_reg, m_valid_next;
    rec_t          out_rec_reg, out_rec_next;
    logic          out_last_reg, out_last_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    rec_t          ram_wdata;
    logic [AW-1:0] ram_raddr;
    rec_t          ram_rdata;

    xchg_ctrl_t    xchg_ctrl;
    rec_t          held;
    logic          swap;

    rec_t          in_rec;
    logic [CW-1:0] outer_inc;
    logic [CW-1:0] inner_inc;
    logic [CW-1:0] emit_inc;

    assign in_rec.key = s_tdata[SCORE_W-1:0];
    assign in_rec.tag = s_tdata[REC_W-1:SCORE_W];
    assign outer_inc  = outer_reg + 1'b1;
    assign inner_inc  = inner_reg + 1'b1;
    assign emit_inc   = emit_reg + 1'b1;

    rxs_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_RECORDS)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rxs_xchg u_xchg (
        .aclk   (aclk),
        .ctrl   (xchg_ctrl),
        .rd_rec (ram_rdata),
        .held   (held),
        .swap   (swap)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        outer_next    = outer_reg;
        inner_next    = inner_reg;
        emit_next     = emit_reg;
        m_valid_next  = m_valid_reg;
        out_rec_next  = out_rec_reg;
        out_last_next = out_last_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = held;
        ram_raddr     = '0;
        xchg_ctrl     = '0;

        unique case (state_reg)
            ST_LOAD: begin
                if (s_tvalid) begin
                    // Records beyond capacity are dropped, but last still starts the sort.
                    if (count_reg < CW'(MAX_RECORDS)) begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[AW-1:0];
                        ram_wdata  = in_rec;
                        count_next = count_reg + 1'b1;
                    end
                    if (s_tlast) begin
                        outer_next = '0;
                        state_next = ST_RD_OUTER;
                    end
                end
            end
            ST_RD_OUTER: begin
                ram_raddr = outer_reg[AW-1:0];
                if (outer_inc < count_reg) begin
                    state_next = ST_GET_OUTER;
                end else begin
                    emit_next  = '0;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_GET_OUTER: begin
                xchg_ctrl.load = 1'b1;
                ram_raddr      = outer_inc[AW-1:0];
                inner_next     = outer_inc;
                state_next     = ST_INNER;
            end
            ST_INNER: begin
                // The read of the next inner position overlaps the write-back of this one.
                xchg_ctrl.step = 1'b1;
                if (swap) begin
                    ram_we    = 1'b1;
                    ram_waddr = inner_reg[AW-1:0];
                end
                if (inner_inc < count_reg) begin
                    ram_raddr  = inner_inc[AW-1:0];
                    inner_next = inner_inc;
                end else begin
                    state_next = ST_PUT_OUTER;
                end
            end
            ST_PUT_OUTER: begin
                ram_we     = 1'b1;
                ram_waddr  = outer_reg[AW-1:0];
                outer_next = outer_inc;
                state_next = ST_RD_OUTER;
            end
            ST_EMIT_RD: begin
                ram_raddr  = emit_reg[AW-1:0];
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                out_rec_next  = ram_rdata;
                out_last_next = (emit_inc == count_reg);
                m_valid_next  = 1'b1;
                state_next    = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    if (out_last_reg) begin
                        count_next = '0;
                        state_next = ST_LOAD;
                    end else begin
                        emit_next  = emit_inc;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            outer_reg   <= '0;
            inner_reg   <= '0;
            emit_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            outer_reg   <= outer_next;
            inner_reg   <= inner_next;
            emit_reg    <= emit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_rec_reg  <= out_rec_next;
        out_last_reg <= out_last_next;
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'({out_rec_reg.tag, out_rec_reg.key});
    assign m_tlast  = out_last_reg;

endmodule

// File: hw/rtl/rxs_checker.sv
// Port-level checks for record_exchange_sort, bound to the top level.
// Depends on rxs_pkg and on the top level's port list.
module rxs_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        s_tlast,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [rxs_pkg::TDATA_W-1:0] m_tdata,
    input logic                        m_tlast
);
    import rxs_pkg::*;

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Input is never taken while a result is on offer.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while emitting");

    // The last record of a set closes the input; this checks that s_tready drops once it is taken.
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still ready after last record");

    // After the final result the block goes back to loading.
    a_final_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
        else $error("block did not return to loading after final result");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[TDATA_W-1:REC_W] == '0)
        else $error("padding bits of result data are not zero");

endmodule

bind record_exchange_sort rxs_checker u_rxs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
